// ----- rtl/core/ghg_pkg.sv -----
package ghg_pkg;

    // Field and register widths
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned MEAN_W   = 16;
    localparam int unsigned RECIP_W  = 32;
    localparam int unsigned GAIN_W   = 32;
    localparam int unsigned SIZE_W   = 13;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned POS_W    = 12;

    // Exponent datapath widths
    localparam int unsigned EXP_W     = 41;
    localparam int unsigned EXP_LOG_W = 21;
    localparam int unsigned SHIFT_W   = 6;

    // Exponent cutoff: 24.0 in Q16.16
    localparam logic [EXP_W-1:0] EXP_LIMIT = EXP_W'(24 << 16);

    // Integer part of the base-2 exponent at which the result shifts out
    localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = SHIFT_W'(32);

    // log2(e) in Q2.30 and ln(2) in Q0.32
    localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
    localparam logic [31:0] LN2_Q32   = 32'hB17217F8;

    // Unity in Q.32
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

    // Taylor series divisor range
    localparam logic [3:0] SERIES_FIRST = 4'd2;
    localparam logic [3:0] SERIES_LAST  = 4'd11;

    // Register map
    typedef enum logic [2:0] {
        REG_MEAN_X       = 3'd0,
        REG_MEAN_Y       = 3'd1,
        REG_RECIP_X      = 3'd2,
        REG_RECIP_Y      = 3'd3,
        REG_GAIN         = 3'd4,
        REG_FRAME_WIDTH  = 3'd5,
        REG_FRAME_HEIGHT = 3'd6
    } reg_idx_t;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4096);

    typedef struct packed {
        logic [MEAN_W-1:0]  mean_x;
        logic [MEAN_W-1:0]  mean_y;
        logic [RECIP_W-1:0] recip_x;
        logic [RECIP_W-1:0] recip_y;
        logic [GAIN_W-1:0]  gain;
        logic [SIZE_W-1:0]  frame_width;
        logic [SIZE_W-1:0]  frame_height;
    } cfg_t;

    // Controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_DIST,
        S_SQX,
        S_SQY,
        S_TX,
        S_TY,
        S_SUM,
        S_LOG,
        S_LN2,
        S_Y,
        S_TM,
        S_RC,
        S_QK,
        S_FIX,
        S_ACC,
        S_GAIN,
        S_SHIFT,
        S_ROUND,
        S_OUT
    } state_t;

    // Operand selection for the shared multiplier
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_SQX,
        MUL_SQY,
        MUL_TX,
        MUL_TY,
        MUL_LOG,
        MUL_LN2,
        MUL_SER,
        MUL_RCP,
        MUL_GAIN
    } mul_sel_t;

    // Datapath register updates
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_DIST,
        OP_SQX,
        OP_SQY,
        OP_TX,
        OP_TY,
        OP_LOG,
        OP_Y,
        OP_RC,
        OP_QK,
        OP_FIX,
        OP_ACC,
        OP_SHIFT,
        OP_ROUND,
        OP_ZERO
    } dp_op_t;

    typedef struct packed {
        dp_op_t   op;
        mul_sel_t mul;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        logic e_big;
        logic n_big;
        logic k_last;
    } sts_t;

    // floor(2^32 / k) for the series divisors
    function automatic logic [31:0] rcp_const(input logic [3:0] k);
        logic [31:0] r;
        case (k)
            4'd2:    r = 32'h80000000;
            4'd3:    r = 32'h55555555;
            4'd4:    r = 32'h40000000;
            4'd5:    r = 32'h33333333;
            4'd6:    r = 32'h2AAAAAAA;
            4'd7:    r = 32'h24924924;
            4'd8:    r = 32'h20000000;
            4'd9:    r = 32'h1C71C71C;
            4'd10:   r = 32'h19999999;
            4'd11:   r = 32'h1745D174;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/ghg_cfg_regs.sv -----
module ghg_cfg_regs
    import ghg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    // Decode the write transaction
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_MEAN_X:       cfg_next.mean_x       = pwdata[MEAN_W-1:0];
                REG_MEAN_Y:       cfg_next.mean_y       = pwdata[MEAN_W-1:0];
                REG_RECIP_X:      cfg_next.recip_x      = pwdata[RECIP_W-1:0];
                REG_RECIP_Y:      cfg_next.recip_y      = pwdata[RECIP_W-1:0];
                REG_GAIN:         cfg_next.gain         = pwdata[GAIN_W-1:0];
                REG_FRAME_WIDTH:  cfg_next.frame_width  = pwdata[SIZE_W-1:0];
                REG_FRAME_HEIGHT: cfg_next.frame_height = pwdata[SIZE_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mean_x       <= '0;
            cfg_reg.mean_y       <= '0;
            cfg_reg.recip_x      <= '0;
            cfg_reg.recip_y      <= '0;
            cfg_reg.gain         <= GAIN_RESET;
            cfg_reg.frame_width  <= SIZE_RESET;
            cfg_reg.frame_height <= SIZE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (idx)
            REG_MEAN_X:       prdata = DATA_W'(cfg_reg.mean_x);
            REG_MEAN_Y:       prdata = DATA_W'(cfg_reg.mean_y);
            REG_RECIP_X:      prdata = DATA_W'(cfg_reg.recip_x);
            REG_RECIP_Y:      prdata = DATA_W'(cfg_reg.recip_y);
            REG_GAIN:         prdata = DATA_W'(cfg_reg.gain);
            REG_FRAME_WIDTH:  prdata = DATA_W'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT: prdata = DATA_W'(cfg_reg.frame_height);
            default:          prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/ghg_ctrl.sv -----
module ghg_ctrl
    import ghg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == S_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_DIST;
            S_DIST:  state_next = S_SQX;
            S_SQX:   state_next = S_SQY;
            S_SQY:   state_next = S_TX;
            S_TX:    state_next = S_TY;
            S_TY:    state_next = S_SUM;
            S_SUM:   state_next = S_LOG;
            S_LOG:   state_next = sts.e_big ? S_OUT : S_LN2;
            S_LN2:   state_next = S_Y;
            S_Y:     state_next = S_TM;
            S_TM:    state_next = S_RC;
            S_RC:    state_next = S_QK;
            S_QK:    state_next = S_FIX;
            S_FIX:   state_next = S_ACC;
            S_ACC:   state_next = sts.k_last ? S_GAIN : S_TM;
            S_GAIN:  state_next = S_SHIFT;
            S_SHIFT: state_next = sts.n_big ? S_OUT : S_ROUND;
            S_ROUND: state_next = S_OUT;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd.op       = OP_NONE;
        cmd.mul      = MUL_NONE;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE:  if (in_valid) cmd.op = OP_LATCH;
            S_DIST:  cmd.op = OP_DIST;
            S_SQX:   cmd.mul = MUL_SQX;
            S_SQY:
            begin
                cmd.mul = MUL_SQY;
                cmd.op  = OP_SQX;
            end
            S_TX:
            begin
                cmd.mul = MUL_TX;
                cmd.op  = OP_SQY;
            end
            S_TY:
            begin
                cmd.mul = MUL_TY;
                cmd.op  = OP_TX;
            end
            S_SUM:   cmd.op = OP_TY;
            S_LOG:
            begin
                if (sts.e_big) cmd.op = OP_ZERO;
                else           cmd.mul = MUL_LOG;
            end
            S_LN2:
            begin
                cmd.mul = MUL_LN2;
                cmd.op  = OP_LOG;
            end
            S_Y:     cmd.op = OP_Y;
            S_TM:    cmd.mul = MUL_SER;
            S_RC:
            begin
                cmd.mul = MUL_RCP;
                cmd.op  = OP_RC;
            end
            S_QK:    cmd.op = OP_QK;
            S_FIX:   cmd.op = OP_FIX;
            S_ACC:   cmd.op = OP_ACC;
            S_GAIN:  cmd.mul = MUL_GAIN;
            S_SHIFT: cmd.op = sts.n_big ? OP_ZERO : OP_SHIFT;
            S_ROUND: cmd.op = OP_ROUND;
            S_OUT:   cmd.load_out = out_free;
            default: cmd.op = OP_NONE;
        endcase
    end

    // Output valid: set on load, drop when the transaction completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item accepted while one is in flight");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten before its transaction");

    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.load_out))
        else $error("output valid raised without a load");
`endif

endmodule

// ----- rtl/core/ghg_datapath.sv -----
module ghg_datapath
    import ghg_pkg::*;
#(
    parameter int unsigned MAX_DIM = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  cmd_t               cmd,
    input  logic               restart,
    output sts_t               sts,
    output logic [VALUE_W-1:0] pixel_value,
    output logic [POS_W-1:0]   pixel_col,
    output logic [POS_W-1:0]   pixel_row,
    output logic               frame_end
);

    localparam int unsigned CW = $clog2(MAX_DIM);
    localparam int unsigned EW = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
    localparam int unsigned DW = (CW + 4 > MEAN_W) ? CW + 4 : MEAN_W;

    // Raster counters
    logic [CW-1:0] col_count_reg;
    logic [CW-1:0] col_count_next;
    logic [CW-1:0] row_count_reg;
    logic [CW-1:0] row_count_next;

    logic [EW-1:0] width_ext;
    logic [EW-1:0] height_ext;
    logic [EW-1:0] w_eff;
    logic [EW-1:0] h_eff;
    logic [CW-1:0] cur_col;
    logic [CW-1:0] cur_row;
    logic [EW-1:0] col_inc;
    logic [EW-1:0] row_inc;
    logic          row_end;
    logic          row_wrap;

    // Pixel under computation
    logic [CW-1:0] pos_col_reg;
    logic [CW-1:0] pos_row_reg;
    logic          fend_reg;

    // Arithmetic registers
    logic [DW-1:0]      ax_reg;
    logic [DW-1:0]      ay_reg;
    logic [DW-1:0]      px16;
    logic [DW-1:0]      py16;
    logic [DW-1:0]      mx_ext;
    logic [DW-1:0]      my_ext;
    logic [31:0]        sx_reg;
    logic [31:0]        sy_reg;
    logic [EXP_W-1:0]   e_reg;
    logic [SHIFT_W-1:0] n_reg;
    logic [31:0]        y_reg;
    logic [31:0]        term_reg;
    logic [32:0]        m_reg;
    logic [31:0]        x_reg;
    logic [31:0]        q_reg;
    logic [31:0]        qk_reg;
    logic [35:0]        qk_full;
    logic [31:0]        rem;
    logic [3:0]         k_reg;
    logic [3:0]         k_next;
    logic [32:0]        v_reg;
    logic [33:0]        rnd;
    logic [VALUE_W-1:0] res_reg;
    logic [31:0]        sat_sq;

    // Shared multiplier
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod_full;
    logic [63:0] prod_next;
    logic [63:0] prod_reg;

    // Output payload
    logic [VALUE_W-1:0] out_value_reg;
    logic [CW-1:0]      out_col_reg;
    logic [CW-1:0]      out_row_reg;
    logic               out_fend_reg;

    // Effective frame size: zero acts as one, oversize clamps
    always_comb
    begin
        width_ext  = EW'(cfg.frame_width);
        height_ext = EW'(cfg.frame_height);
        if (width_ext == '0)
            w_eff = EW'(1);
        else if (width_ext > EW'(MAX_DIM))
            w_eff = EW'(MAX_DIM);
        else
            w_eff = width_ext;
        if (height_ext == '0)
            h_eff = EW'(1);
        else if (height_ext > EW'(MAX_DIM))
            h_eff = EW'(MAX_DIM);
        else
            h_eff = height_ext;
    end

    // Position of the accepted pixel and the raster advance
    assign cur_col  = restart ? '0 : col_count_reg;
    assign cur_row  = restart ? '0 : row_count_reg;
    assign col_inc  = EW'(cur_col) + EW'(1);
    assign row_inc  = EW'(cur_row) + EW'(1);
    assign row_end  = (col_inc >= w_eff);
    assign row_wrap = (row_inc >= h_eff);

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (cmd.op == OP_LATCH)
        begin
            if (row_end)
            begin
                col_count_next = '0;
                row_count_next = row_wrap ? '0 : CW'(row_inc);
            end
            else
            begin
                col_count_next = CW'(col_inc);
                row_count_next = cur_row;
            end
        end
    end

    // Series index
    always_comb
    begin
        k_next = k_reg;
        case (cmd.op)
            OP_Y:    k_next = SERIES_FIRST;
            OP_ACC:  k_next = k_reg + 4'd1;
            default: k_next = k_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            k_reg         <= SERIES_FIRST;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            k_reg         <= k_next;
        end
    end

    // Distance of the pixel from the center, Q.4
    assign px16   = DW'({pos_col_reg, 4'b0000});
    assign py16   = DW'({pos_row_reg, 4'b0000});
    assign mx_ext = DW'(cfg.mean_x);
    assign my_ext = DW'(cfg.mean_y);

    // Multiplier operand selection
    always_comb
    begin
        case (cmd.mul)
            MUL_SQX:
            begin
                mul_a = 32'(ax_reg);
                mul_b = 32'(ax_reg);
            end
            MUL_SQY:
            begin
                mul_a = 32'(ay_reg);
                mul_b = 32'(ay_reg);
            end
            MUL_TX:
            begin
                mul_a = sx_reg;
                mul_b = cfg.recip_x;
            end
            MUL_TY:
            begin
                mul_a = sy_reg;
                mul_b = cfg.recip_y;
            end
            MUL_LOG:
            begin
                mul_a = 32'(e_reg[EXP_LOG_W-1:0]);
                mul_b = LOG2E_Q30;
            end
            MUL_LN2:
            begin
                mul_a = prod_reg[45:14];
                mul_b = LN2_Q32;
            end
            MUL_SER:
            begin
                mul_a = term_reg;
                mul_b = y_reg;
            end
            MUL_RCP:
            begin
                mul_a = prod_reg[63:32];
                mul_b = rcp_const(k_reg);
            end
            MUL_GAIN:
            begin
                mul_a = cfg.gain;
                mul_b = m_reg[31:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = 64'(mul_a) * 64'(mul_b);

    // A mantissa of exactly one shifts the gain up a word
    assign prod_next = ((cmd.mul == MUL_GAIN) && m_reg[32]) ? {cfg.gain, 32'h0} : prod_full;

    // Helpers for the capture steps
    assign sat_sq  = (prod_reg[63:32] != 32'h0) ? 32'hFFFFFFFF : prod_reg[31:0];
    assign qk_full = 36'(prod_reg[63:32]) * 36'(k_reg);
    assign rem     = x_reg - qk_reg;
    assign rnd     = 34'(v_reg) + 34'd1;

    // Datapath registers, advanced by the controller
    always_ff @(posedge clk)
    begin
        if (cmd.mul != MUL_NONE)
        begin
            prod_reg <= prod_next;
        end
        case (cmd.op)
            OP_LATCH:
            begin
                pos_col_reg <= cur_col;
                pos_row_reg <= cur_row;
                fend_reg    <= row_end && row_wrap;
            end
            OP_DIST:
            begin
                ax_reg <= (px16 >= mx_ext) ? px16 - mx_ext : mx_ext - px16;
                ay_reg <= (py16 >= my_ext) ? py16 - my_ext : my_ext - py16;
            end
            OP_SQX:  sx_reg <= sat_sq;
            OP_SQY:  sy_reg <= sat_sq;
            OP_TX:   e_reg <= EXP_W'(prod_reg[63:24]);
            OP_TY:   e_reg <= e_reg + EXP_W'(prod_reg[63:24]);
            OP_LOG:  n_reg <= prod_reg[51:46];
            OP_Y:
            begin
                y_reg    <= prod_reg[63:32];
                term_reg <= prod_reg[63:32];
                m_reg    <= ONE_Q32 - 33'(prod_reg[63:32]);
            end
            OP_RC:   x_reg <= prod_reg[63:32];
            OP_QK:
            begin
                q_reg  <= prod_reg[63:32];
                qk_reg <= qk_full[31:0];
            end
            // One correction step brings the quotient estimate to the floor
            OP_FIX:  term_reg <= q_reg + 32'(rem >= 32'(k_reg));
            OP_ACC:  m_reg <= k_reg[0] ? m_reg - 33'(term_reg) : m_reg + 33'(term_reg);
            OP_SHIFT: v_reg <= 33'((prod_reg >> 31) >> n_reg[4:0]);
            OP_ROUND: res_reg <= rnd[32:1];
            OP_ZERO:  res_reg <= '0;
            default:  res_reg <= res_reg;
        endcase
        if (cmd.load_out)
        begin
            out_value_reg <= res_reg;
            out_col_reg   <= pos_col_reg;
            out_row_reg   <= pos_row_reg;
            out_fend_reg  <= fend_reg;
        end
    end

    // Status to the controller
    assign sts.e_big  = (e_reg >= EXP_LIMIT);
    assign sts.n_big  = (n_reg >= SHIFT_LIMIT);
    assign sts.k_last = (k_reg == SERIES_LAST);

    assign pixel_value = out_value_reg;
    assign pixel_col   = POS_W'(out_col_reg);
    assign pixel_row   = POS_W'(out_row_reg);
    assign frame_end   = out_fend_reg;

`ifndef SYNTHESIS
    a_rcp_fix: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FIX) |-> (rem < (32'(k_reg) << 1)))
        else $error("reciprocal quotient estimate off by more than one");

    a_m_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_ACC) |=> (m_reg <= ONE_Q32))
        else $error("series mantissa above one");
`endif

endmodule

// ----- rtl/core/gaussian_heatmap_generator_top.sv -----
// Channel   Handshake            Payload
// config    psel/penable/pready  paddr, pwdata, pwrite, prdata
// input     in_valid/in_ready    restart
// output    out_valid/out_ready  pixel_value, pixel_col, pixel_row, frame_end
//
// One pixel is computed at a time; an exponent of 24 or more skips to the
// output, and a result that shifts out entirely skips the rounding.
// The pace is set by the single shared 32x32 multiplier and the ten-step
// exp series, each step a product, a reciprocal product and a correction.
// The output register holds a finished pixel while the next one is accepted.
// rst_n clears the raster counters, the state machine and the config registers
// to their reset values; a stalled output holds the datapath in its last state.
module gaussian_heatmap_generator_top
    import ghg_pkg::*;
#(
    parameter int unsigned MAX_DIM = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               restart,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VALUE_W-1:0] pixel_value,
    output logic [POS_W-1:0]   pixel_col,
    output logic [POS_W-1:0]   pixel_row,
    output logic               frame_end
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    // Register file
    ghg_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer
    ghg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Raster counters and arithmetic
    ghg_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .restart     (restart),
        .sts         (sts),
        .pixel_value (pixel_value),
        .pixel_col   (pixel_col),
        .pixel_row   (pixel_row),
        .frame_end   (frame_end)
    );

endmodule

// ----- tb/gaussian_heatmap_generator_top_test.sv -----
module gaussian_heatmap_generator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ghg_pkg::*;

    localparam int unsigned FRAME_MAX    = 4096;
    localparam int unsigned UNMAPPED_IDX = 7;
    localparam int unsigned RANDOM_ITEMS = 700;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned TAIL_CYCLES  = 80;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   row;
        logic               last;
    } pixel_t;

    // Tracks the raster position and configuration, predicts each pixel
    class pixel_scoreboard;
        logic [MEAN_W-1:0]  mean_x;
        logic [MEAN_W-1:0]  mean_y;
        logic [RECIP_W-1:0] recip_x;
        logic [RECIP_W-1:0] recip_y;
        logic [GAIN_W-1:0]  gain;
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
        int unsigned        col_pos;
        int unsigned        row_pos;
        pixel_t             expected_pixels[$];
        int unsigned        errors;
        int unsigned        checked;
        int unsigned        zeros;
        int unsigned        frame_ends;
        int unsigned        restarts;

        function new();
            mean_x     = '0;
            mean_y     = '0;
            recip_x    = '0;
            recip_y    = '0;
            gain       = GAIN_RESET;
            width      = SIZE_RESET;
            height     = SIZE_RESET;
            col_pos    = 0;
            row_pos    = 0;
            errors     = 0;
            checked    = 0;
            zeros      = 0;
            frame_ends = 0;
            restarts   = 0;
        endfunction

        function void set_reg(int unsigned idx, logic [DATA_W-1:0] v);
            case (idx)
                REG_MEAN_X:       mean_x  = v[MEAN_W-1:0];
                REG_MEAN_Y:       mean_y  = v[MEAN_W-1:0];
                REG_RECIP_X:      recip_x = v;
                REG_RECIP_Y:      recip_y = v;
                REG_GAIN:         gain    = v;
                REG_FRAME_WIDTH:  width   = v[SIZE_W-1:0];
                REG_FRAME_HEIGHT: height  = v[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        // Zero acts as one, oversize acts as the maximum
        function int unsigned clamp_size(logic [SIZE_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > FRAME_MAX)
                return FRAME_MAX;
            return v;
        endfunction

        // Squared distance times recip, exponent in Q16.16
        function logic [63:0] axis_energy(int unsigned pos, logic [MEAN_W-1:0] center,
                                          logic [RECIP_W-1:0] r);
            logic [63:0] p16;
            logic [63:0] a;
            logic [63:0] s;
            p16 = 64'(pos) << 4;
            a = (p16 >= 64'(center)) ? p16 - 64'(center) : 64'(center) - p16;
            s = a * a;
            if (s > 64'hFFFF_FFFF)
                s = 64'hFFFF_FFFF;
            return (s * 64'(r)) >> 24;
        endfunction

        // exp(-y) for y in Q0.32 by a truncated Taylor series, Q.32 result
        function logic [63:0] exp_neg_frac(logic [63:0] y);
            logic [63:0] m;
            logic [63:0] term;
            m = 64'h1_0000_0000;
            term = 64'h1_0000_0000;
            for (int k = 1; k <= 11; k++)
            begin
                term = ((term * y) >> 32) / 64'(k);
                if (k % 2 == 1)
                    m = m - term;
                else
                    m = m + term;
            end
            return m;
        endfunction

        function logic [VALUE_W-1:0] gauss_at(int unsigned col, int unsigned row);
            logic [63:0] e;
            logic [63:0] t;
            logic [63:0] n;
            logic [63:0] g;
            logic [63:0] y;
            logic [63:0] m;
            logic [63:0] p;
            int unsigned sh;
            e = axis_energy(col, mean_x, recip_x) + axis_energy(row, mean_y, recip_y);
            if (e >= 64'(24 << 16))
                return '0;
            t = (e * 64'(LOG2E_Q30)) >> 14;
            n = t >> 32;
            g = t & 64'hFFFF_FFFF;
            y = (g * 64'(LN2_Q32)) >> 32;
            m = exp_neg_frac(y);
            sh = 32 + int'(n);
            if (sh >= 64)
                return '0;
            p = 64'(gain) * m;
            p = ((p >> (sh - 1)) + 64'd1) >> 1;
            return p[31:0];
        endfunction

        // Predict the pixel for one accepted tick and advance the raster
        function void note_tick(bit restart_bit);
            pixel_t      px;
            int unsigned w;
            int unsigned h;
            bit          row_done;
            w = clamp_size(width);
            h = clamp_size(height);
            if (restart_bit)
            begin
                col_pos = 0;
                row_pos = 0;
                restarts++;
            end
            row_done = (col_pos + 1) >= w;
            px.value = gauss_at(col_pos, row_pos);
            px.col   = col_pos[POS_W-1:0];
            px.row   = row_pos[POS_W-1:0];
            px.last  = row_done && ((row_pos + 1) >= h);
            expected_pixels.insert(expected_pixels.size(), px);
            if (row_done)
            begin
                col_pos = 0;
                if ((row_pos + 1) >= h)
                    row_pos = 0;
                else
                    row_pos++;
            end
            else
                col_pos++;
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (expected_pixels.size() == 0)
            begin
                $error("pixel at col %0d row %0d arrived with no tick pending", got.col, got.row);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            if (got.value !== want.value)
            begin
                $error("pixel_value mismatch: expected %h, actual %h", want.value, got.value);
                errors++;
            end
            if (got.col !== want.col)
            begin
                $error("pixel_col mismatch: expected %0d, actual %0d", want.col, got.col);
                errors++;
            end
            if (got.row !== want.row)
            begin
                $error("pixel_row mismatch: expected %0d, actual %0d", want.row, got.row);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("frame_end mismatch: expected %b, actual %b", want.last, got.last);
                errors++;
            end
            checked++;
            if (got.value == 0)
                zeros++;
            if (got.last)
                frame_ends++;
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic               restart;
    logic               out_valid;
    logic               out_ready;
    logic [VALUE_W-1:0] pixel_value;
    logic [POS_W-1:0]   pixel_col;
    logic [POS_W-1:0]   pixel_row;
    logic               frame_end;

    pixel_scoreboard sb;
    bit              steady;
    bit              squeeze_req;
    int unsigned     config_count;

    gaussian_heatmap_generator_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_value (pixel_value),
        .pixel_col   (pixel_col),
        .pixel_row   (pixel_row),
        .frame_end   (frame_end)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Idle about a quarter of the cycles unless a steady stretch is running
    function automatic bit idle_roll();
        return !steady && ($urandom_range(0, 99) < 25);
    endfunction

    // Setup cycle, then access cycle; the register takes the value on pready
    task automatic apb_write(int unsigned idx, logic [DATA_W-1:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx << 2);
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        sb.set_reg(idx, v);
        config_count++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one tick and hold it until accepted
    task automatic send_tick(bit rs);
        @(negedge clk);
        while (idle_roll())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rs;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        sb.note_tick(rs);
    endtask

    // Drop valid and wait until every predicted pixel has come out
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [RECIP_W-1:0] pick_recip();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom() >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic [MEAN_W-1:0] pick_mean(int unsigned span);
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return '0;
            2:       return MEAN_W'($urandom());
            default: return MEAN_W'($urandom_range(0, (span + 32 > 65535) ? 65535 : span + 32));
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size(int unsigned common_max);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SIZE_W'(4096);
            2:       return SIZE_W'($urandom_range(4097, 8191));
            3:       return SIZE_W'($urandom_range(1, 4096));
            default: return SIZE_W'($urandom_range(1, common_max));
        endcase
    endfunction

    // Pick a fresh setting; the raster keeps its position across the change
    task automatic random_config();
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
        logic [GAIN_W-1:0] g;
        w = pick_size(24);
        h = pick_size(16);
        case ($urandom_range(0, 5))
            0:       g = '0;
            1:       g = '1;
            2:       g = GAIN_RESET;
            default: g = $urandom();
        endcase
        apb_write(REG_FRAME_WIDTH, DATA_W'(w));
        apb_write(REG_FRAME_HEIGHT, DATA_W'(h));
        apb_write(REG_MEAN_X, DATA_W'(pick_mean(sb.clamp_size(w) * 16)));
        apb_write(REG_MEAN_Y, DATA_W'(pick_mean(sb.clamp_size(h) * 16)));
        apb_write(REG_RECIP_X, pick_recip());
        apb_write(REG_RECIP_Y, pick_recip());
        apb_write(REG_GAIN, g);
        if ($urandom_range(0, 7) == 0)
            apb_write(UNMAPPED_IDX, $urandom());
    endtask

    // Receiver: random stalls, one long hold-off, check every transaction
    initial
    begin
        int unsigned hold_left;
        pixel_t      got;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (squeeze_req)
            begin
                squeeze_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= !idle_roll();
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready === 1'b1)
            begin
                got.value = pixel_value;
                got.col   = pixel_col;
                got.row   = pixel_row;
                got.last  = frame_end;
                sb.check_pixel(got);
            end
        end
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int unsigned sent;
        int unsigned phase;
        int unsigned len;
        int unsigned steady_phase;
        int unsigned squeeze_phase;
        sb           = new();
        steady       = 1'b0;
        squeeze_req  = 1'b0;
        config_count = 0;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        restart  = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset configuration: unity peak at the origin
        send_tick(1'b0);
        send_tick(1'b1);
        drain();

        // Oversize frame and an unmapped register
        apb_write(REG_FRAME_WIDTH, DATA_W'(8191));
        apb_write(REG_FRAME_HEIGHT, DATA_W'(8191));
        apb_write(UNMAPPED_IDX, $urandom());
        send_tick(1'b0);
        drain();

        // Small off-center frame, one full pass with wrap and frame end
        apb_write(REG_MEAN_X, DATA_W'(16'h0018));
        apb_write(REG_MEAN_Y, DATA_W'(16'h0008));
        apb_write(REG_RECIP_X, 32'h4000_0000);
        apb_write(REG_RECIP_Y, 32'h8000_0000);
        apb_write(REG_GAIN, 32'h0003_8000);
        apb_write(REG_FRAME_WIDTH, DATA_W'(3));
        apb_write(REG_FRAME_HEIGHT, DATA_W'(2));
        send_tick(1'b1);
        repeat (5) send_tick(1'b0);
        drain();

        // Zero frame size, far center, zero gain
        apb_write(REG_MEAN_X, DATA_W'(16'hFFFF));
        apb_write(REG_MEAN_Y, DATA_W'(16'hFFFF));
        apb_write(REG_RECIP_X, 32'hFFFF_FFFF);
        apb_write(REG_RECIP_Y, 32'hFFFF_FFFF);
        apb_write(REG_GAIN, 32'h0000_0000);
        apb_write(REG_FRAME_WIDTH, DATA_W'(0));
        apb_write(REG_FRAME_HEIGHT, DATA_W'(0));
        send_tick(1'b0);
        send_tick(1'b0);
        drain();

        // One row crossing the shift-out band just below the cutoff
        apb_write(REG_MEAN_X, DATA_W'(0));
        apb_write(REG_MEAN_Y, DATA_W'(0));
        apb_write(REG_RECIP_X, 32'd3951369912);
        apb_write(REG_RECIP_Y, 32'd0);
        apb_write(REG_GAIN, 32'hFFFF_FFFF);
        apb_write(REG_FRAME_WIDTH, DATA_W'(8));
        apb_write(REG_FRAME_HEIGHT, DATA_W'(1));
        send_tick(1'b1);
        repeat (6) send_tick(1'b0);
        drain();

        // Shrink the frame under the running column
        apb_write(REG_FRAME_WIDTH, DATA_W'(2));
        send_tick(1'b0);
        send_tick(1'b0);
        drain();

        // Random settings, each followed by a burst of ticks
        sent = 0;
        phase = 0;
        steady_phase = $urandom_range(0, 3);
        squeeze_phase = steady_phase + 2;
        while (sent < RANDOM_ITEMS)
        begin
            random_config();
            len = $urandom_range(20, 80);
            if (phase == steady_phase)
            begin
                len = 80;
                steady = 1'b1;
            end
            if (phase == squeeze_phase)
            begin
                len = 60;
                squeeze_req = 1'b1;
            end
            repeat (len) send_tick($urandom_range(0, 19) == 0);
            sent += len;
            phase++;
            drain();
            steady = 1'b0;
        end

        // Let any stray pixel show up before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Checked %0d pixels over %0d register writes and %0d random settings",
                 sb.checked, config_count, phase);
        $display("Saw %0d restarts, %0d frame ends and %0d zero-valued pixels",
                 sb.restarts, sb.frame_ends, sb.zeros);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/ghg_pkg.sv
rtl/core/ghg_cfg_regs.sv
rtl/core/ghg_ctrl.sv
rtl/core/ghg_datapath.sv
rtl/core/gaussian_heatmap_generator_top.sv
tb/gaussian_heatmap_generator_top_test.sv
